// ===== design/graph_mean_pooling_macros.svh =====
// ----------------------------------------------------------------------------
// Graph mean pooling assertion macros
// Concurrent assertion wrappers, sampled on clk and held off during arst_n.
// ----------------------------------------------------------------------------
`ifndef GRAPH_MEAN_POOLING_MACROS_SVH
`define GRAPH_MEAN_POOLING_MACROS_SVH

`ifndef SYNTHESIS

`define GMP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("graph_mean_pooling assertion failed");

`define GMP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("graph_mean_pooling assertion failed");

`else

`define GMP_ASSERT(lbl, prop)

`define GMP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/gmp_pkg.sv =====
// ----------------------------------------------------------------------------
// Graph mean pooling package
// Word types of the two streams and constants shared by the design files.
// ----------------------------------------------------------------------------
package gmp_pkg;

	localparam int ELEM_W = 32;
	localparam int DIM_W  = 6;
	localparam int CNT_W  = 13;

	typedef struct packed {
		logic signed [ELEM_W-1:0] elem_value;
		logic [DIM_W-1:0]         dim_index;
		logic                     first_node;
		logic                     last_node;
	} gmp_elem_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] mean_value;
		logic [DIM_W-1:0]         out_dim;
	} gmp_mean_t;

	typedef struct packed {
		logic             valid;
		logic [DIM_W-1:0] dim;
	} gmp_tag_t;

endpackage

// ===== design/gmp_stream_if.sv =====
// ----------------------------------------------------------------------------
// Graph mean pooling stream interface
// Valid/ready channel that moves one word per accepted handshake.
// ----------------------------------------------------------------------------
interface gmp_stream_if #(
	parameter type data_t = logic
) ();

	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// ===== design/graph_mean_pooling.sv =====
// ----------------------------------------------------------------------------
// Graph mean pooling
// Per-dimension running sums of node embeddings and their floor mean.
// ----------------------------------------------------------------------------
// Words arrive on elem: one embedding element, its dimension, and first and
// last node flags. A first-node word starts the dimension's sum, later words
// add to it with wraparound, and a last-node word sends the floor of the sum
// divided by node_count on mean. Other words and words whose dimension is at
// or above EMB_DIMS produce nothing. node_count is written through cfg_wr_en
// and cfg_wr_data; the user must write it only while the block is idle, and
// the block itself does not enforce this; zero acts as one. One word is
// accepted per cycle while the spare output entry is empty. The divider
// retires one quotient bit per stage.
// Reset clears node_count to one and empties the pipeline; the sums are
// undefined until a first-node word writes them.
// The output holds a result register and a spare entry behind it; the
// pipeline keeps flowing while one result waits and halts only when both are
// full, so a stalled receiver loses and repeats nothing.
// ----------------------------------------------------------------------------
`include "graph_mean_pooling_macros.svh"

module graph_mean_pooling #(
	parameter int EMB_DIMS    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [gmp_pkg::CNT_W-1:0] cfg_wr_data,
	gmp_stream_if.sink                elem,
	gmp_stream_if.source              mean
);
	import gmp_pkg::*;

	localparam int AW = (EMB_DIMS > 1) ? $clog2(EMB_DIMS) : 1;
	localparam int VW = VALUE_WIDTH;

	logic [CNT_W-1:0] div_q;
	logic             adv;

	logic [AW+DIM_W-1:0] dim_ext;
	logic [AW-1:0]       rd_addr;
	logic                in_range;
	logic [VW+ELEM_W-1:0] v_ext;

	logic [VW-1:0] sum_mem [0:EMB_DIMS-1];

	logic             vld_s1;
	logic [VW-1:0]    v_s1;
	logic [AW-1:0]    dim_s1;
	logic [DIM_W-1:0] odim_s1;
	logic             first_s1;
	logic             last_s1;
	logic [VW-1:0]    rd_s1;
	logic             byp_s1;
	logic [VW-1:0]    bypd_s1;
	logic [VW-1:0]    base_s1;
	logic [VW-1:0]    sum_s1;
	logic             wr_en;

	logic             vld_s2;
	logic [DIM_W-1:0] odim_s2;
	logic [VW-1:0]    sum_s2;
	gmp_tag_t         tag_s2;

	gmp_tag_t              div_tag;
	logic [VW-1:0]         quo;
	logic [VW+ELEM_W-1:0]  q_ext;
	gmp_mean_t             push_data;
	logic                  push;
	logic                  pop;

	logic      out_vld_q;
	logic      skd_vld_q;
	gmp_mean_t out_q;
	gmp_mean_t skd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= CNT_W'(1);
		end else if (cfg_wr_en) begin
			div_q <= (cfg_wr_data == '0) ? CNT_W'(1) : cfg_wr_data;
		end
	end

	assign adv        = !skd_vld_q;
	assign elem.ready = adv;

	assign dim_ext  = {AW'(0), elem.data.dim_index};
	assign rd_addr  = dim_ext[AW-1:0];
	assign in_range = {5'd0, elem.data.dim_index} < 11'(EMB_DIMS);
	assign v_ext    = {{VW{elem.data.elem_value[ELEM_W-1]}}, elem.data.elem_value};

	assign base_s1 = byp_s1 ? bypd_s1 : rd_s1;
	assign sum_s1  = first_s1 ? v_s1 : base_s1 + v_s1;
	assign wr_en   = adv && vld_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (wr_en) begin
				sum_mem[dim_s1] <= sum_s1;
			end
			rd_s1 <= sum_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= elem.valid && in_range;
			vld_s2 <= vld_s1 && last_s1;
		end
	end

	// The read at the edge of a write to the same entry sees the old value.
	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1     <= v_ext[VW-1:0];
			dim_s1   <= rd_addr;
			odim_s1  <= elem.data.dim_index;
			first_s1 <= elem.data.first_node;
			last_s1  <= elem.data.last_node;
			byp_s1   <= wr_en && (dim_s1 == rd_addr);
			bypd_s1  <= sum_s1;
			sum_s2   <= sum_s1;
			odim_s2  <= odim_s1;
		end
	end

	assign tag_s2.valid = vld_s2;
	assign tag_s2.dim   = odim_s2;

	gmp_floor_div #(
		.W(VW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.div     (div_q),
		.in_tag  (tag_s2),
		.num     (sum_s2),
		.out_tag (div_tag),
		.quo     (quo)
	);

	assign q_ext                = {{ELEM_W{quo[VW-1]}}, quo};
	assign push_data.mean_value = q_ext[ELEM_W-1:0];
	assign push_data.out_dim    = div_tag.dim;
	assign push                 = adv && div_tag.valid;
	assign pop                  = out_vld_q && mean.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skd_vld_q <= 1'b0;
		end else begin
			if (pop && skd_vld_q) begin
				skd_vld_q <= 1'b0;
			end else if (push) begin
				out_vld_q <= 1'b1;
				if (out_vld_q && !pop) begin
					skd_vld_q <= 1'b1;
				end
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skd_vld_q) begin
			out_q <= skd_q;
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skd_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

	assign mean.valid = out_vld_q;
	assign mean.data  = out_q;

	`GMP_ASSERT(a_skid_behind_out, skd_vld_q |-> out_vld_q)
	`GMP_ASSERT_NEXT(a_skid_drains, pop && skd_vld_q, out_vld_q && !skd_vld_q)
	`GMP_ASSERT_NEXT(a_push_to_skid, push && out_vld_q && !pop, skd_vld_q && out_vld_q)

endmodule

// ===== design/gmp_floor_div.sv =====
// ----------------------------------------------------------------------------
// Graph mean pooling floor divider
// Pipelined restoring divider, one quotient bit per stage, rounding to minus
// infinity for a signed dividend and a positive divisor.
// ----------------------------------------------------------------------------
module gmp_floor_div #(
	parameter int W = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic [gmp_pkg::CNT_W-1:0] div,
	input  gmp_pkg::gmp_tag_t        in_tag,
	input  logic [W-1:0]             num,
	output gmp_pkg::gmp_tag_t        out_tag,
	output logic [W-1:0]             quo
);
	import gmp_pkg::*;

	gmp_tag_t         tag_s [0:W];
	logic             neg_s [0:W];
	logic [W-1:0]     nq_s  [0:W];
	logic [CNT_W-1:0] rem_s [0:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s[0] <= '0;
		end else if (adv) begin
			tag_s[0] <= in_tag;
		end
	end

	// A negative dividend s is divided as ~s and the quotient inverted back.
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s[0] <= num[W-1];
			nq_s[0]  <= num[W-1] ? ~num : num;
			rem_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < W; k++) begin : g_step
		logic [CNT_W:0] trial;
		logic [CNT_W:0] diff;
		logic           ge;

		assign trial = {rem_s[k], nq_s[k][W-1]};
		assign diff  = trial - {1'b0, div};
		assign ge    = trial >= {1'b0, div};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k+1] <= '0;
			end else if (adv) begin
				tag_s[k+1] <= tag_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				neg_s[k+1] <= neg_s[k];
				nq_s[k+1]  <= {nq_s[k][W-2:0], ge};
				rem_s[k+1] <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			end
		end
	end

	assign out_tag = tag_s[W];
	assign quo     = neg_s[W] ? ~nq_s[W] : nq_s[W];

endmodule
